[rtl/pspq_pkg.sv]
// shared types and constants of the process slot pool and ready queue
package pspq_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int WIDE_W = (PTR_W > 3) ? PTR_W : 3;

    localparam logic [PTR_W-1:0] PTR_NONE = PTR_W'(SLOTS);

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_ENQUEUE = 2'd2,
        REQ_DEQUEUE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_EMPTY   = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } pspq_cmd_t;

endpackage

[rtl/pspq_ctrl.sv]
// controller: input handshake, execute sequencing and output valid
module pspq_ctrl
    import pspq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output pspq_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd.capture   = 1'b0;
        cmd.execute   = 1'b0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result goes out only once the output register is free
                if (out_free) begin
                    cmd.execute   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new item accepted while one is in progress");

    a_exec_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending item");

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> m_tvalid)
        else $error("executed request produced no result");
`endif

endmodule

[rtl/pspq_datapath.sv]
// datapath: slot busy table, link table, queue pointers and result register
module pspq_datapath
    import pspq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pspq_cmd_t cmd,
    input  logic [1:0] in_req_type,
    input  logic [2:0] in_slot,
    output logic [2:0] out_result_slot,
    output logic [1:0] out_status
);

    logic [SLOTS-1:0]  busy_reg;
    logic [PTR_W-1:0]  link_reg [SLOTS];
    logic [PTR_W-1:0]  head_reg, tail_reg;

    req_t              req_reg;
    logic [2:0]        slot_reg;
    logic [2:0]        res_slot_reg, res_slot_next;
    status_t           res_status_reg, res_status_next;

    logic [WIDE_W-1:0] slot_wide;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              head_ok, tail_ok;
    logic [SLOT_W-1:0] head_idx, tail_idx;
    logic [PTR_W-1:0]  head_link;

    function automatic logic [2:0] low3(input logic [SLOT_W-1:0] idx);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(idx);
        return w[2:0];
    endfunction

    assign slot_wide = WIDE_W'(slot_reg);
    assign slot_ok   = slot_wide < WIDE_W'(SLOTS);
    assign slot_idx  = slot_wide[SLOT_W-1:0];
    assign head_ok   = head_reg != PTR_NONE;
    assign tail_ok   = tail_reg != PTR_NONE;
    assign head_idx  = head_reg[SLOT_W-1:0];
    assign tail_idx  = tail_reg[SLOT_W-1:0];
    assign head_link = link_reg[head_idx];

    // lowest free slot wins
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        res_slot_next   = slot_reg;
        res_status_next = STAT_OK;
        case (req_reg)
            REQ_ALLOC: begin
                if (free_found) begin
                    res_slot_next = low3(free_idx);
                end else begin
                    res_status_next = STAT_NO_FREE;
                end
            end
            REQ_DEQUEUE: begin
                if (head_ok) begin
                    res_slot_next = low3(head_idx);
                end else begin
                    res_status_next = STAT_EMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= req_t'(in_req_type);
            slot_reg <= in_slot;
        end
        if (cmd.execute) begin
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                link_reg[i] <= PTR_NONE;
            end
            head_reg <= PTR_NONE;
            tail_reg <= PTR_NONE;
        end else if (cmd.execute) begin
            case (req_reg)
                REQ_ALLOC: begin
                    if (free_found) begin
                        busy_reg[free_idx] <= 1'b1;
                    end
                end
                REQ_RELEASE: begin
                    if (slot_ok) begin
                        busy_reg[slot_idx] <= 1'b0;
                        link_reg[slot_idx] <= PTR_NONE;
                    end
                end
                REQ_ENQUEUE: begin
                    if (slot_ok) begin
                        // old tail links to the slot unless it is the slot itself
                        if (tail_ok && tail_idx != slot_idx) begin
                            link_reg[tail_idx] <= PTR_W'(slot_idx);
                        end else if (!tail_ok) begin
                            head_reg <= PTR_W'(slot_idx);
                        end
                        tail_reg <= PTR_W'(slot_idx);
                        // the new tail always ends the chain
                        link_reg[slot_idx] <= PTR_NONE;
                    end
                end
                REQ_DEQUEUE: begin
                    if (head_ok) begin
                        if (head_link != PTR_NONE) begin
                            head_reg <= head_link;
                        end else begin
                            head_reg <= PTR_NONE;
                            tail_reg <= PTR_NONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign out_result_slot = res_slot_reg;
    assign out_status      = res_status_reg;

`ifndef SYNTHESIS
    a_head_tail_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == PTR_NONE) == (tail_reg == PTR_NONE))
        else $error("queue head and tail disagree on empty");

    a_alloc_marks_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && req_reg == REQ_ALLOC && free_found) |=> busy_reg[$past(free_idx)])
        else $error("allocated slot not marked busy");

    a_tail_link_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && req_reg == REQ_ENQUEUE && slot_ok) |=> link_reg[tail_idx] == PTR_NONE)
        else $error("new tail keeps a stale link");
`endif

endmodule

[rtl/process_slot_pool_ready_queue_unit.sv]
// Process slot pool with a linked FIFO ready queue threaded through the slots.
//
// Input channel s_*: one request per item. s_tuser carries the request kind
// (allocate, release, enqueue, dequeue) and s_tdata[2:0] the slot index used
// by release and enqueue. Result channel m_*: one result item per request,
// m_tdata[2:0] the allocated, dequeued or echoed slot and m_tuser the status
// (ok, no free slot, queue empty).
// A request is captured into the request register when accepted, then
// executed against the slot tables once the output register is free, and its
// result is registered into the output register. The two-state controller
// captures a request and then executes it, so a new request is accepted
// only after the previous one has been executed.
// When the receiver stalls, the result waits in the output register while
// the next request is still accepted; that request then waits to execute
// until the output register is taken. Reset frees every slot, clears all
// links and empties the queue.
module process_slot_pool_ready_queue_unit
    import pspq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [2:0] slot, [7:3] zero
    input  logic [1:0] s_tuser,   // [1:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] result_slot, [7:3] zero
    output logic [1:0] m_tuser    // [1:0] status
);

    pspq_cmd_t  cmd;
    logic [2:0] result_slot;

    pspq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pspq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_req_type     (s_tuser),
        .in_slot         (s_tdata[2:0]),
        .out_result_slot (result_slot),
        .out_status      (m_tuser)
    );

    assign m_tdata = {5'b0, result_slot};

endmodule
